/* rtl/deadline_ordered_work_queue_defines.svh */
// Assertion macros used by the checker file.
`ifndef DEADLINE_ORDERED_WORK_QUEUE_DEFINES_SVH
`define DEADLINE_ORDERED_WORK_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DOWQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DOWQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dowq_pkg.sv */
`default_nettype none

package dowq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int MAX_RESULTS = 16;

  localparam int OPCODE_W  = 3;
  localparam int WORK_ID_W = 8;
  localparam int TIME_W    = 32;
  localparam int STATUS_W  = 3;

  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int DISP_W = $clog2(MAX_RESULTS);

  localparam int IN_FIELDS_W  = OPCODE_W + WORK_ID_W + TIME_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STATUS_W + WORK_ID_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SCHED_AT    = 3'd0,
    OP_SCHED_AFTER = 3'd1,
    OP_CANCEL      = 3'd2,
    OP_RESCHED     = 3'd3,
    OP_TICK        = 3'd4
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_PAST       = 3'd1,
    ST_NOT_FOUND  = 3'd2,
    ST_CANCELLED  = 3'd3,
    ST_FULL       = 3'd4,
    ST_NO_CURRENT = 3'd5
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture the input transaction
    logic prep;     // form deadline / advance time
    logic exec;     // run a non-dispatch operation
    logic pop;      // dispatch the head entry
    logic last;     // tlast for the result being formed
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic head_due;
    logic next_due;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/dowq_datapath.sv */
`default_nettype none

module dowq_datapath
  import dowq_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire dp_cmd_t                 cmd_i,
  output dp_stat_t                     stat_o,
  input  wire logic [OPCODE_W-1:0]     opcode_i,
  input  wire logic [WORK_ID_W-1:0]    work_id_i,
  input  wire logic [TIME_W-1:0]       time_value_i,
  output logic [STATUS_W-1:0]          status_o,
  output logic                         dispatch_valid_o,
  output logic [WORK_ID_W-1:0]         dispatched_id_o
);

  // captured operation
  logic [OPCODE_W-1:0] op_q;
  logic [ID_BITS-1:0]  id_q;
  logic [TIME_W-1:0]   tv_q;
  logic [TIME_W-1:0]   dl_q;
  logic [ID_BITS-1:0]  tgt_q;

  // sorted queue, head in cell 0
  logic [TIME_W-1:0]  cell_dl_q [QUEUE_DEPTH];
  logic [ID_BITS-1:0] cell_id_q [QUEUE_DEPTH];
  logic [TIME_W-1:0]  cell_dl_d [QUEUE_DEPTH];
  logic [ID_BITS-1:0] cell_id_d [QUEUE_DEPTH];

  logic [CNT_W-1:0]   count_q;
  logic [TIME_W-1:0]  time_q;
  logic [ID_BITS-1:0] cur_id_q;
  logic               cur_present_q;
  logic               cur_cancel_q;

  logic [STATUS_W-1:0]  status_q;
  logic                 dv_q;
  logic [ID_BITS-1:0]   did_q;

  logic [QUEUE_DEPTH-1:0] le_mask, match_mask, rem_mask;
  logic [TIME_W-1:0]      sum;
  logic                   is_past, is_full, cur_hit;
  logic                   do_ins, do_rem;
  logic [STATUS_W-1:0]    op_status;

  assign sum = time_q + ((op_q == OP_TICK) ? TIME_W'(1) : tv_q);

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      le_mask[i]    = (CNT_W'(i) < count_q) && (cell_dl_q[i] <= dl_q);
      match_mask[i] = (CNT_W'(i) < count_q) && (cell_id_q[i] == id_q);
      // set from the first matching cell upward
      rem_mask[i]   = |(match_mask & ({QUEUE_DEPTH{1'b1}} >> (QUEUE_DEPTH - 1 - i)));
    end
  end

  assign is_past = dl_q < time_q;
  assign is_full = count_q == CNT_W'(QUEUE_DEPTH);
  assign cur_hit = cur_present_q && (id_q == cur_id_q);

  always_comb begin
    do_ins    = 1'b0;
    do_rem    = 1'b0;
    op_status = ST_OK;
    case (op_q)
      OP_SCHED_AT, OP_SCHED_AFTER: begin
        if (is_past)      op_status = ST_PAST;
        else if (is_full) op_status = ST_FULL;
        else              do_ins    = 1'b1;
      end
      OP_CANCEL: begin
        if (!cur_hit) begin
          if (|match_mask) do_rem    = 1'b1;
          else             op_status = ST_NOT_FOUND;
        end
      end
      OP_RESCHED: begin
        if (!cur_present_q)     op_status = ST_NO_CURRENT;
        else if (cur_cancel_q)  op_status = ST_CANCELLED;
        else if (is_past)       op_status = ST_PAST;
        else if (is_full)       op_status = ST_FULL;
        else                    do_ins    = 1'b1;
      end
      default: op_status = ST_OK;
    endcase
    if (!cmd_i.exec) begin
      do_ins = 1'b0;
      do_rem = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      int up;
      int dn;
      up = (i < QUEUE_DEPTH - 1) ? i + 1 : i;
      dn = (i > 0) ? i - 1 : i;
      cell_dl_d[i] = cell_dl_q[i];
      cell_id_d[i] = cell_id_q[i];
      if (cmd_i.pop || (do_rem && rem_mask[i])) begin
        cell_dl_d[i] = cell_dl_q[up];
        cell_id_d[i] = cell_id_q[up];
      end else if (do_ins && !le_mask[i]) begin
        if (i == 0 || le_mask[dn]) begin
          cell_dl_d[i] = dl_q;
          cell_id_d[i] = tgt_q;
        end else begin
          cell_dl_d[i] = cell_dl_q[dn];
          cell_id_d[i] = cell_id_q[dn];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cell_dl_q[i] <= cell_dl_d[i];
      cell_id_q[i] <= cell_id_d[i];
    end
    if (cmd_i.load) begin
      op_q <= opcode_i;
      id_q <= ID_BITS'(work_id_i);
      tv_q <= time_value_i;
    end
    if (cmd_i.prep) begin
      dl_q  <= (op_q == OP_SCHED_AT) ? tv_q : sum;
      tgt_q <= (op_q == OP_RESCHED) ? cur_id_q : id_q;
    end
    if (cmd_i.pop) begin
      status_q <= ST_OK;
      dv_q     <= 1'b1;
      did_q    <= cell_id_q[0];
    end else if (cmd_i.exec) begin
      status_q <= (op_q == OP_TICK) ? STATUS_W'(ST_OK) : op_status;
      dv_q     <= 1'b0;
      did_q    <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      time_q        <= '0;
      cur_id_q      <= '0;
      cur_present_q <= 1'b0;
      cur_cancel_q  <= 1'b0;
    end else begin
      if (cmd_i.prep && op_q == OP_TICK) time_q <= sum;
      if (cmd_i.pop) begin
        count_q       <= count_q - CNT_W'(1);
        cur_id_q      <= cell_id_q[0];
        cur_present_q <= 1'b1;
        cur_cancel_q  <= 1'b0;
      end else if (do_ins) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_rem) begin
        count_q <= count_q - CNT_W'(1);
      end
      if (cmd_i.exec && op_q == OP_CANCEL && cur_hit) cur_cancel_q <= 1'b1;
    end
  end

  assign stat_o.is_tick  = op_q == OP_TICK;
  assign stat_o.head_due = (count_q != '0) && (cell_dl_q[0] < time_q);
  assign stat_o.next_due = (count_q > CNT_W'(1)) && (cell_dl_q[1] < time_q);

  assign status_o         = status_q;
  assign dispatch_valid_o = dv_q;
  assign dispatched_id_o  = WORK_ID_W'(did_q);

endmodule

`default_nettype wire

/* rtl/dowq_ctrl.sv */
`default_nettype none

module dowq_ctrl
  import dowq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output logic          out_last_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_EXEC,
    S_OUT
  } state_e;

  state_e            state_q;
  logic              rdy_q;
  logic              vld_q;
  logic              last_q;
  logic [DISP_W-1:0] n_q;
  logic              pop_last;

  // last dispatch of this tick: nothing more due or the per-tick cap reached
  assign pop_last = !stat_i.next_due || (n_q == DISP_W'(MAX_RESULTS - 1));

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: cmd_o.load = in_valid_i && rdy_q;
      S_PREP: cmd_o.prep = 1'b1;
      S_EXEC: begin
        if (stat_i.is_tick && stat_i.head_due) begin
          cmd_o.pop  = 1'b1;
          cmd_o.last = pop_last;
        end else begin
          cmd_o.exec = 1'b1;
          cmd_o.last = 1'b1;
        end
      end
      S_OUT: cmd_o = '0;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rdy_q   <= 1'b1;
      vld_q   <= 1'b0;
      last_q  <= 1'b0;
      n_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && rdy_q) begin
            rdy_q   <= 1'b0;
            n_q     <= '0;
            state_q <= S_PREP;
          end
        end
        S_PREP: state_q <= S_EXEC;
        S_EXEC: begin
          last_q  <= cmd_o.last;
          vld_q   <= 1'b1;
          if (cmd_o.pop) n_q <= n_q + DISP_W'(1);
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) begin
            vld_q <= 1'b0;
            if (last_q) begin
              rdy_q   <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              state_q <= S_EXEC;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = rdy_q;
  assign out_valid_o = vld_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

/* rtl/deadline_ordered_work_queue.sv */
// Each item passes the accept, prepare, execute and output states in order; the
//   result is registered in the execute state and held until it is taken, and a
//   new item is accepted only after the last result; a tick that dispatches entries
//   repeats execute and output for each, one insert/remove step per result.
// Reset (rst_ni, async, active low): queue empty, time zero, no current entry,
//   ready high; no clearing pass.
`default_nettype none

module deadline_ordered_work_queue
  import dowq_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // [2:0] opcode, [10:3] work_id, [42:11] time_value, rest zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [2:0] status, [10:3] dispatched_id, rest zero
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  // [0] dispatch_valid
  output logic                        m_axis_tuser,
  output logic                        m_axis_tlast
);

  dp_cmd_t               cmd;
  dp_stat_t              stat;
  logic [STATUS_W-1:0]   status;
  logic [WORK_ID_W-1:0]  dispatched_id;

  dowq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_last_o  (m_axis_tlast),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dowq_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .opcode_i         (s_axis_tdata[OPCODE_W-1:0]),
    .work_id_i        (s_axis_tdata[OPCODE_W +: WORK_ID_W]),
    .time_value_i     (s_axis_tdata[OPCODE_W + WORK_ID_W +: TIME_W]),
    .status_o         (status),
    .dispatch_valid_o (m_axis_tuser),
    .dispatched_id_o  (dispatched_id)
  );

  assign m_axis_tdata = OUT_TDATA_W'({dispatched_id, status});

endmodule

`default_nettype wire

/* rtl/dowq_checker.sv */
`default_nettype none

`include "deadline_ordered_work_queue_defines.svh"

module dowq_checker
  import dowq_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic                   m_axis_tuser,
  input wire logic                   m_axis_tlast
);

  // one operation in flight: input side closed while a result is offered
  `DOWQ_ASSERT_IMP(a_one_in_flight, m_axis_tvalid, !s_axis_tready,
                   "ready while result pending")

  `DOWQ_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
                   "accepted twice")

  // a non-dispatch result always closes the transaction and carries no id
  `DOWQ_ASSERT_IMP(a_plain_is_last, m_axis_tvalid && !m_axis_tuser,
                   m_axis_tlast && (m_axis_tdata[OUT_TDATA_W-1:STATUS_W] == '0),
                   "plain result not last")

  `DOWQ_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata), "result dropped")

endmodule

bind deadline_ordered_work_queue dowq_checker u_dowq_checker (.*);

`default_nettype wire
